FILE: rtl/mrcp_pkg.sv
package mrcp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_DONE    = 2'd1;
  localparam logic [1:0] KIND_ERR     = 2'd2;
  localparam logic [1:0] KIND_TIMEOUT = 2'd3;

  // Line phases
  localparam logic [1:0] PH_HEAD = 2'd0;
  localparam logic [1:0] PH_MORE = 2'd1;
  localparam logic [1:0] PH_END  = 2'd2;
  localparam logic [1:0] PH_DROP = 2'd3;

  // Line position while streaming
  localparam logic [2:0] POS_STRIP = 3'd4;
  localparam logic [2:0] POS_PLAIN = 3'd5;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [31:0] TIMEOUT_RESET = 32'd10000;
  localparam int          MAX_RES       = 5;

  typedef struct packed {
    logic       func;
    logic [7:0] in_byte;
    logic       last_of_line;
  } in_req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [9:0] code;
    logic       last;
  } out_res_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_val;
    logic [9:0] code;
  } res_ent_t;

  // All results caused by one accepted request, in order.
  typedef struct packed {
    logic [2:0]                 cnt;
    res_ent_t [MAX_RES-1:0]     ent;
  } cmd_t;

  function automatic res_ent_t mk_res(logic [1:0] kind, logic [7:0] b, logic [9:0] code);
    res_ent_t r;
    r.kind     = kind;
    r.byte_val = b;
    r.code     = code;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

FILE: rtl/multiline_reply_code_parser_core.sv
// An accepted request's results are queued as one command and offered from the queue head.
// Throughput: one request per cycle while the queue is not full; a request with k results
// holds the output until all k are taken, and the command queue (QUEUE_DEPTH entries)
// absorbs these bursts before input stalls. Requests that cause no result skip the queue.
// Reset (synchronous, rst_n low): queue empty, parser at start of a reply, timeout 10000.
module multiline_reply_code_parser_core
  import mrcp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_req_t     in_req,
  output logic        out_valid,
  input  logic        out_stall,
  output out_res_t    out_res,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic q_full, q_empty, q_push, q_pop;
  cmd_t q_cmd, q_head;

  mrcp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_req    (in_req),
    .in_stall  (in_stall),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  mrcp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head_cmd (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  mrcp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

`ifndef SYNTH
  a_reset_no_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");
  a_status_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_res.kind == KIND_TIMEOUT || out_res.kind == KIND_ERR)
    |-> out_res.code == 10'd0 && out_res.out_byte == 8'd0)
    else $error("error or timeout result carries a code or byte");
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.kind == KIND_DONE |-> out_res.last)
    else $error("reply complete is not the final result of its request");
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full && !q_pop |-> !q_push)
    else $error("command pushed into a full queue");
`endif

endmodule

FILE: rtl/mrcp_front.sv
module mrcp_front
  import mrcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  in_req_t     in_req,
  output logic        in_stall,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic [31:0]     timeout_r;
  logic [9:0]      saved_r, saved_nxt;
  logic            set_r, set_nxt;
  logic [3:0][7:0] head_r, head_nxt;
  logic [2:0]      pos_r, pos_nxt;
  logic [1:0]      phase_r, phase_nxt;
  logic [31:0]     elapsed_r, elapsed_nxt;
  logic            acc;
  cmd_t            cmd;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  always_comb begin
    logic [2:0]  n;
    logic [7:0]  b;
    logic        eol;
    logic [1:0]  idx;
    logic [2:0]  cnt;
    logic        digits;
    logic [9:0]  value;
    logic [7:0]  d3;
    logic        strip;
    logic        bad;
    logic        same;
    n           = 3'd0;
    cmd.ent     = '0;
    saved_nxt   = saved_r;
    set_nxt     = set_r;
    head_nxt    = head_r;
    pos_nxt     = pos_r;
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    b           = in_req.in_byte;
    eol         = in_req.last_of_line;
    idx         = pos_r[1:0];
    cnt         = {1'b0, idx} + 3'd1;
    digits      = 1'b0;
    value       = 10'd0;
    d3          = 8'd0;
    strip       = 1'b0;
    bad         = 1'b0;
    same        = 1'b0;
    if (in_req.func) begin
      if (elapsed_r != 32'hFFFF_FFFF) begin
        elapsed_nxt = elapsed_r + 32'd1;
      end
      if (elapsed_nxt >= timeout_r) begin
        cmd.ent[n] = mk_res(KIND_TIMEOUT, 8'd0, 10'd0);
        n = n + 3'd1;
        set_nxt     = 1'b0;
        elapsed_nxt = 32'd0;
        if (phase_r == PH_HEAD && pos_r == 3'd0) begin
          phase_nxt = PH_HEAD;
          pos_nxt   = 3'd0;
        end else begin
          phase_nxt = PH_DROP;
        end
      end
    end else if (phase_r == PH_HEAD) begin
      head_nxt[idx] = b;
      pos_nxt       = cnt;
      if (cnt == 3'd4 || eol) begin
        digits = (cnt >= 3'd3) && is_digit(head_nxt[0]) && is_digit(head_nxt[1])
                 && is_digit(head_nxt[2]);
        value  = 10'(head_nxt[0][3:0]) * 10'd100 + 10'(head_nxt[1][3:0]) * 10'd10
                 + 10'(head_nxt[2][3:0]);
        if (!set_r) begin
          d3 = (cnt == 3'd3) ? CH_SPACE : head_nxt[3];
          if (!digits || (d3 != CH_SPACE && d3 != CH_DASH)) begin
            bad = 1'b1;
            cmd.ent[n] = mk_res(KIND_ERR, 8'd0, 10'd0);
            n = n + 3'd1;
            set_nxt     = 1'b0;
            elapsed_nxt = 32'd0;
            if (eol) begin
              phase_nxt = PH_HEAD;
              pos_nxt   = 3'd0;
            end else begin
              phase_nxt = PH_DROP;
            end
          end else begin
            saved_nxt = value;
            set_nxt   = (d3 == CH_DASH);
            phase_nxt = (d3 == CH_SPACE) ? PH_END : PH_MORE;
            pos_nxt   = POS_PLAIN;
          end
        end else begin
          same = (cnt == 3'd4) && digits && (value == saved_r);
          if (same && (head_nxt[3] == CH_SPACE || head_nxt[3] == CH_DASH)) begin
            phase_nxt = (head_nxt[3] == CH_SPACE) ? PH_END : PH_MORE;
            pos_nxt   = POS_PLAIN;
          end else begin
            // A line not opened by the saved code and a space or dash is joined with one space.
            cmd.ent[n] = mk_res(KIND_BYTE, CH_SPACE, saved_r);
            n = n + 3'd1;
            strip = 1'b1;
            for (int i = 0; i < 4; i++) begin
              if (3'(i) < cnt && !(strip && head_nxt[i] == CH_SPACE)) begin
                strip = 1'b0;
                cmd.ent[n] = mk_res(KIND_BYTE, head_nxt[i], saved_r);
                n = n + 3'd1;
              end
            end
            phase_nxt = PH_MORE;
            pos_nxt   = strip ? POS_STRIP : POS_PLAIN;
          end
        end
        if (eol && !bad) begin
          if (phase_nxt == PH_END) begin
            cmd.ent[n] = mk_res(KIND_DONE, 8'd0, saved_nxt);
            n = n + 3'd1;
            set_nxt     = 1'b0;
            elapsed_nxt = 32'd0;
          end
          phase_nxt = PH_HEAD;
          pos_nxt   = 3'd0;
        end
      end
    end else if (phase_r == PH_DROP) begin
      if (eol) begin
        phase_nxt = PH_HEAD;
        pos_nxt   = 3'd0;
      end
    end else begin
      strip = (pos_r == POS_STRIP);
      if (!(strip && b == CH_SPACE)) begin
        strip = 1'b0;
        cmd.ent[n] = mk_res(KIND_BYTE, b, saved_r);
        n = n + 3'd1;
      end
      pos_nxt = strip ? POS_STRIP : POS_PLAIN;
      if (eol) begin
        if (phase_r == PH_END) begin
          cmd.ent[n] = mk_res(KIND_DONE, 8'd0, saved_r);
          n = n + 3'd1;
          set_nxt     = 1'b0;
          elapsed_nxt = 32'd0;
        end
        phase_nxt = PH_HEAD;
        pos_nxt   = 3'd0;
      end
    end
    cmd.cnt = n;
  end

  assign q_push = acc && (cmd.cnt != 3'd0);
  assign q_cmd  = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
      saved_r   <= 10'd0;
      set_r     <= 1'b0;
      pos_r     <= 3'd0;
      phase_r   <= PH_HEAD;
      elapsed_r <= 32'd0;
    end else begin
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
      if (acc) begin
        saved_r   <= saved_nxt;
        set_r     <= set_nxt;
        pos_r     <= pos_nxt;
        phase_r   <= phase_nxt;
        elapsed_r <= elapsed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      head_r <= head_nxt;
    end
  end

endmodule

FILE: rtl/mrcp_queue.sv
module mrcp_queue
  import mrcp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head_cmd,
  output logic full,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t            mem_r [DEPTH];
  logic [AW-1:0]   wr_r, rd_r;
  logic [CW-1:0]   count_r;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

endmodule

FILE: rtl/mrcp_back.sv
module mrcp_back
  import mrcp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  cmd_t     q_head,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_stall,
  output out_res_t out_res
);

  logic [2:0] idx_r;
  logic       is_last;
  res_ent_t   ent;

  assign ent       = q_head.ent[idx_r];
  assign is_last   = (idx_r == q_head.cnt - 3'd1);
  assign out_valid = !q_empty;
  assign q_pop     = out_valid && !out_stall && is_last;

  always_comb begin
    out_res.kind     = ent.kind;
    out_res.out_byte = ent.byte_val;
    out_res.code     = ent.code;
    out_res.last     = is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 3'd0;
    end else if (out_valid && !out_stall) begin
      idx_r <= is_last ? 3'd0 : idx_r + 3'd1;
    end
  end

endmodule

FILE: test/testbench.sv
module testbench;
  import mrcp_pkg::*;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 55;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_req_t     in_req = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_res_t    out_res;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  multiline_reply_code_parser_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Parser state as the block should hold it.
  logic [31:0] tick_limit = TIMEOUT_RESET;
  logic [9:0]  reply_code = '0;
  logic        code_open = 1'b0;
  logic [7:0]  head_chars [4] = '{default: 8'd0};
  logic [2:0]  line_pos = '0;
  logic [1:0]  line_stage = PH_HEAD;
  logic [31:0] tick_count = '0;

  out_res_t made [MAX_RES];
  int       made_n;

  in_req_t  requests_to_send [$];
  out_res_t parser_results_due [$];
  int       queued = 0;
  int       mismatches = 0;
  int       cycle_count = 0;
  bit       idle_on = 1'b1;
  bit       ticks_on = 1'b0;
  bit       accepted = 1'b0;
  int       gap_left = 0;
  int       stall_left = 0;
  out_res_t want;

  task automatic emit(input logic [1:0] kind, input logic [7:0] b, input logic [9:0] code);
    out_res_t r;
    r.kind = kind;
    r.out_byte = b;
    r.code = code;
    r.last = 1'b0;
    made[made_n] = r;
    made_n++;
  endtask

  task automatic close_reply();
    code_open = 1'b0;
    tick_count = '0;
  endtask

  task automatic start_line();
    line_stage = PH_HEAD;
    line_pos = '0;
  endtask

  // Leading spaces of a free-text later line are dropped until the first other character.
  task automatic stream_char(input logic [7:0] b, inout logic strip);
    if (!(strip && b == CH_SPACE)) begin
      strip = 1'b0;
      emit(KIND_BYTE, b, reply_code);
    end
  endtask

  task automatic finish_head(input logic eol);
    logic [7:0] d3;
    logic       digits;
    logic       strip;
    logic [9:0] value;
    int         i;
    d3 = head_chars[3];
    digits = line_pos >= 3 &&
             head_chars[0] >= CH_ZERO && head_chars[0] <= CH_NINE &&
             head_chars[1] >= CH_ZERO && head_chars[1] <= CH_NINE &&
             head_chars[2] >= CH_ZERO && head_chars[2] <= CH_NINE;
    value = digits ? 10'((head_chars[0] - CH_ZERO) * 100 + (head_chars[1] - CH_ZERO) * 10
                         + (head_chars[2] - CH_ZERO)) : 10'd0;
    if (!code_open) begin
      if (line_pos == 3) d3 = CH_SPACE;
      if (!digits || (d3 != CH_SPACE && d3 != CH_DASH)) begin
        emit(KIND_ERR, 8'd0, 10'd0);
        close_reply();
        if (eol) start_line();
        else line_stage = PH_DROP;
        return;
      end
      reply_code = value;
      if (d3 == CH_DASH) code_open = 1'b1;
      line_stage = (d3 == CH_SPACE) ? PH_END : PH_MORE;
      line_pos = POS_PLAIN;
    end else if (line_pos == 4 && digits && value == reply_code &&
                 (d3 == CH_SPACE || d3 == CH_DASH)) begin
      line_stage = (d3 == CH_SPACE) ? PH_END : PH_MORE;
      line_pos = POS_PLAIN;
    end else begin
      strip = 1'b1;
      emit(KIND_BYTE, CH_SPACE, reply_code);
      for (i = 0; i < line_pos; i++) stream_char(head_chars[i], strip);
      line_stage = PH_MORE;
      line_pos = strip ? POS_STRIP : POS_PLAIN;
    end
    if (eol) begin
      if (line_stage == PH_END) begin
        emit(KIND_DONE, 8'd0, reply_code);
        close_reply();
      end
      start_line();
    end
  endtask

  task automatic parse_request(input in_req_t r);
    logic strip;
    int   i;
    made_n = 0;
    if (r.func == FUNC_TICK) begin
      if (tick_count != '1) tick_count++;
      if (tick_count >= tick_limit) begin
        emit(KIND_TIMEOUT, 8'd0, 10'd0);
        close_reply();
        if (line_stage == PH_HEAD && line_pos == 0) start_line();
        else line_stage = PH_DROP;
      end
    end else if (line_stage == PH_HEAD) begin
      head_chars[line_pos[1:0]] = r.in_byte;
      line_pos = {1'b0, line_pos[1:0]} + 3'd1;
      if (line_pos == 4 || r.last_of_line) finish_head(r.last_of_line);
    end else if (line_stage == PH_DROP) begin
      if (r.last_of_line) start_line();
    end else begin
      strip = (line_pos == POS_STRIP);
      stream_char(r.in_byte, strip);
      line_pos = strip ? POS_STRIP : POS_PLAIN;
      if (r.last_of_line) begin
        if (line_stage == PH_END) begin
          emit(KIND_DONE, 8'd0, reply_code);
          close_reply();
        end
        start_line();
      end
    end
    if (made_n > 0) made[made_n - 1].last = 1'b1;
    for (i = 0; i < made_n; i++) parser_results_due.push_back(made[i]);
  endtask

  // Driver: predict on every accepted request, present the next one at the falling edge.
  always @(posedge clk) begin
    accepted = rst_n && in_valid && !in_stall;
    if (accepted) parse_request(in_req);
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || accepted)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        gap_left = $urandom_range(1, 6) - 1;
      end else if (requests_to_send.size() > 0) begin
        in_valid <= 1'b1;
        in_req <= requests_to_send.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(1, 6) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input int expected, input int actual);
    if (expected != actual) begin
      $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
      mismatches++;
    end
  endtask

  // Monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (parser_results_due.size() == 0) begin
        $error("result with nothing pending: kind %0d byte %0d code %0d",
               out_res.kind, out_res.out_byte, out_res.code);
        mismatches++;
      end else begin
        want = parser_results_due.pop_front();
        check_field("kind", want.kind, out_res.kind);
        check_field("out_byte", want.out_byte, out_res.out_byte);
        check_field("code", want.code, out_res.code);
        check_field("last", want.last, out_res.last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic queue_request(input logic f, input logic [7:0] b, input logic eol);
    in_req_t r;
    r.func = f;
    r.in_byte = b;
    r.last_of_line = eol;
    requests_to_send.push_back(r);
    queued++;
  endtask

  task automatic send_line(input logic [7:0] chars [$]);
    int i;
    for (i = 0; i < chars.size(); i++) begin
      if (ticks_on && $urandom_range(0, 11) == 0)
        queue_request(FUNC_TICK, 8'($urandom), 1'($urandom));
      queue_request(FUNC_BYTE, chars[i], i == chars.size() - 1);
    end
  endtask

  task automatic queue_text(input string s);
    logic [7:0] chars [$];
    int         i;
    for (i = 0; i < s.len(); i++) chars.push_back(s[i]);
    send_line(chars);
  endtask

  function automatic logic [7:0] text_char();
    if ($urandom_range(0, 5) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h20, 8'h7e));
  endfunction

  task automatic put_code(inout logic [7:0] chars [$], input int code);
    chars.push_back(CH_ZERO + 8'(code / 100));
    chars.push_back(CH_ZERO + 8'((code / 10) % 10));
    chars.push_back(CH_ZERO + 8'(code % 10));
  endtask

  // One reply: a first line, then continuation lines and usually a closing line.
  task automatic queue_reply();
    logic [7:0] chars [$];
    int         code;
    int         extra;
    int         k;
    code = $urandom_range(0, 999);
    extra = $urandom_range(0, 3);
    put_code(chars, code);
    if (!(extra == 0 && $urandom_range(0, 3) == 0)) begin
      chars.push_back(extra == 0 ? CH_SPACE : CH_DASH);
      repeat ($urandom_range(0, 5)) chars.push_back(text_char());
    end
    if ($urandom_range(0, 9) == 0) chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom);
    if ($urandom_range(0, 15) == 0)
      while (chars.size() > 2) void'(chars.pop_back());
    send_line(chars);
    for (k = 0; k < extra; k++) begin
      chars = {};
      if (k == extra - 1) begin
        put_code(chars, code);
        if ($urandom_range(0, 7) != 0) chars.push_back(CH_SPACE);
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            put_code(chars, code);
            chars.push_back(CH_DASH);
          end
          1: repeat ($urandom_range(0, 3)) chars.push_back(CH_SPACE);
          default: begin
            put_code(chars, (code + 1) % 1000);
            chars.push_back($urandom_range(0, 1) ? CH_DASH : CH_SPACE);
          end
        endcase
      end
      repeat ($urandom_range(0, 5)) chars.push_back(text_char());
      if (chars.size() == 0) chars.push_back(text_char());
      send_line(chars);
    end
  endtask

  task automatic queue_noise_line();
    logic [7:0] chars [$];
    repeat ($urandom_range(1, 8)) chars.push_back(8'($urandom));
    send_line(chars);
  endtask

  // Holds the sender until every predicted result has come back.
  task automatic drain();
    while (!(requests_to_send.size() == 0 && !in_valid && parser_results_due.size() == 0))
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    tick_limit = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  logic [31:0] limits [7] = '{32'hFFFF_FFFF, 32'd0, 32'd2, 32'd5, 32'd12, 32'd40,
                              TIMEOUT_RESET};

  initial begin
    int start;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    queue_text("12");
    queue_text("000");
    queue_text("999-\377");
    queue_request(FUNC_TICK, 8'hFF, 1'b1);
    queue_text("  a");
    queue_text("999 ");
    queue_text("12a-z");
    queue_text("123x");
    drain();

    ticks_on = 1'b1;
    foreach (limits[i]) begin
      write_limit(limits[i]);
      // The middle and last phases run without any idling.
      idle_on = (i != 3 && i != 6);
      start = queued;
      while (queued - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 5) == 0) queue_noise_line();
        else queue_reply();
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

FILE: files.f
rtl/mrcp_pkg.sv
rtl/mrcp_front.sv
rtl/mrcp_queue.sv
rtl/mrcp_back.sv
rtl/multiline_reply_code_parser_core.sv
test/testbench.sv
